/* src/rmq_pkg.sv */
`default_nettype none

package rmq_pkg;

   localparam int DIN_W      = 32;            // matrix entry and quaternion width
   localparam int CAND_W     = 35;            // signed candidate, 1 + three entries
   localparam int PAIR_W     = 33;            // signed off-diagonal sum or difference
   localparam int BEST_W     = 33;            // clamped candidate magnitude
   localparam int FRAC_SHIFT = 28;            // radicand and dividend prescale
   localparam int RAD_W      = 62;            // radicand, even width for digit pairs
   localparam int ROOT_W     = 31;
   localparam int REM_W      = 33;
   localparam int QUO_W      = 32;
   localparam int DREM_W     = 31;            // divider partial remainder, below root
   localparam int DTOP_W     = PAIR_W - 4;    // dividend bits loaded into remainder
   localparam int NSLOT      = 3;             // components found by division
   localparam int NCOMP      = 4;
   localparam int NPAIR      = 6;
   localparam int SQRT_STEPS = RAD_W / 2;
   localparam int DIV_STEPS  = QUO_W;

   localparam logic signed [CAND_W-1:0] ONE_Q30 = CAND_W'(1 << 30);

   // off-diagonal pair codes, named by the two components they join
   localparam logic [2:0] PAIR_WX = 3'd0;
   localparam logic [2:0] PAIR_WY = 3'd1;
   localparam logic [2:0] PAIR_WZ = 3'd2;
   localparam logic [2:0] PAIR_XY = 3'd3;
   localparam logic [2:0] PAIR_XZ = 3'd4;
   localparam logic [2:0] PAIR_YZ = 3'd5;

   typedef logic [1:0] comp_type;

   typedef struct packed {
      comp_type                           idx;
      logic [NSLOT-1:0]                   neg;
      logic [NSLOT-1:0][PAIR_W-1:0]       mag;
   } side_type;

   typedef struct packed {
      side_type                           side;
      logic [RAD_W-1:0]                   rad;
      logic [REM_W-1:0]                   rem;
      logic [ROOT_W-1:0]                  root;
   } sqrt_type;

   typedef struct packed {
      comp_type                           idx;
      logic [NSLOT-1:0]                   neg;
      logic [ROOT_W-1:0]                  root;
      logic [NSLOT-1:0][DREM_W-1:0]       r;
      logic [NSLOT-1:0][QUO_W-1:0]        nq;
   } div_type;

   // component of division slot s when component k took the root
   function automatic comp_type slot_comp(input comp_type k, input logic [1:0] s);
      comp_type c;
      c = (s < k) ? s : comp_type'(s + 2'd1);
      return c;
   endfunction

endpackage

`default_nettype wire

/* src/rmq_front.sv */
`default_nettype none

module rmq_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               adv,
   input  wire logic                               in_valid,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   m00,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   m01,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   m02,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   m10,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   m11,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   m12,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   m20,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   m21,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   m22,
   output logic                                    out_valid,
   output rmq_pkg::sqrt_type                       out_data
);
   import rmq_pkg::*;

   function automatic logic [2:0] pair_of(input comp_type a, input comp_type b);
      logic [2:0] p;
      case ({(a < b) ? a : b, (a < b) ? b : a})
         4'b00_01: p = PAIR_WX;
         4'b00_10: p = PAIR_WY;
         4'b00_11: p = PAIR_WZ;
         4'b01_10: p = PAIR_XY;
         4'b01_11: p = PAIR_XZ;
         default:  p = PAIR_YZ;
      endcase
      return p;
   endfunction

   logic                            va_ff, vb_ff, vc_ff;
   logic signed [CAND_W-1:0]        cand_ff [NCOMP];
   logic signed [CAND_W-1:0]        cand_in [NCOMP];
   logic signed [PAIR_W-1:0]        pa_ff [NPAIR];
   logic signed [PAIR_W-1:0]        pa_in [NPAIR];
   logic signed [PAIR_W-1:0]        pb_ff [NPAIR];
   logic signed [CAND_W-1:0]        best_ff, best_in;
   comp_type                        idx_ff, idx_in;
   sqrt_type                        c_ff, c_in;

   // stage a: candidates and off-diagonal terms
   always_comb begin
      cand_in[0] = ONE_Q30 + CAND_W'(m00) + CAND_W'(m11) + CAND_W'(m22);
      cand_in[1] = ONE_Q30 + CAND_W'(m00) - CAND_W'(m11) - CAND_W'(m22);
      cand_in[2] = ONE_Q30 - CAND_W'(m00) + CAND_W'(m11) - CAND_W'(m22);
      cand_in[3] = ONE_Q30 - CAND_W'(m00) - CAND_W'(m11) + CAND_W'(m22);
      pa_in[PAIR_WX] = PAIR_W'(m21) - PAIR_W'(m12);
      pa_in[PAIR_WY] = PAIR_W'(m02) - PAIR_W'(m20);
      pa_in[PAIR_WZ] = PAIR_W'(m10) - PAIR_W'(m01);
      pa_in[PAIR_XY] = PAIR_W'(m01) + PAIR_W'(m10);
      pa_in[PAIR_XZ] = PAIR_W'(m02) + PAIR_W'(m20);
      pa_in[PAIR_YZ] = PAIR_W'(m12) + PAIR_W'(m21);
   end

   // stage b: largest candidate, earliest wins a tie
   always_comb begin
      best_in = cand_ff[0];
      idx_in  = 2'd0;
      for (int i = 1; i < NCOMP; i++) begin
         if (best_in < cand_ff[i]) begin
            best_in = cand_ff[i];
            idx_in  = comp_type'(i);
         end
      end
   end

   // stage c: radicand and division slots
   always_comb begin
      logic signed [PAIR_W-1:0] num;
      logic [BEST_W-1:0]        bmag;
      bmag = best_ff[CAND_W-1] ? '0 : best_ff[BEST_W-1:0];
      c_in.rad  = {{(RAD_W - BEST_W - FRAC_SHIFT){1'b0}}, bmag, {FRAC_SHIFT{1'b0}}};
      c_in.rem  = '0;
      c_in.root = '0;
      c_in.side.idx = idx_ff;
      for (int s = 0; s < NSLOT; s++) begin
         num = pb_ff[pair_of(idx_ff, slot_comp(idx_ff, 2'(s)))];
         c_in.side.neg[s] = num[PAIR_W-1];
         c_in.side.mag[s] = num[PAIR_W-1] ? PAIR_W'(-num) : PAIR_W'(num);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cand_ff <= cand_in;
         pa_ff   <= pa_in;
         pb_ff   <= pa_ff;
         best_ff <= best_in;
         idx_ff  <= idx_in;
         c_ff    <= c_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_data  = c_ff;

endmodule

`default_nettype wire

/* src/rmq_sqrt_stage.sv */
`default_nettype none

module rmq_sqrt_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 in_valid,
   input  wire rmq_pkg::sqrt_type    in_data,
   output logic                      out_valid,
   output rmq_pkg::sqrt_type         out_data
);
   import rmq_pkg::*;

   logic                 valid_ff;
   sqrt_type             data_ff, data_in;
   logic [REM_W+1:0]     trial, test;
   logic                 ge;

   // one root digit: bring down two radicand bits, try 4*root+1
   always_comb begin
      trial = {in_data.rem, in_data.rad[RAD_W-1 -: 2]};
      test  = {1'b0, in_data.root, 2'b01};
      ge    = trial >= test;
      data_in      = in_data;
      data_in.rem  = ge ? REM_W'(trial - test) : trial[REM_W-1:0];
      data_in.root = {in_data.root[ROOT_W-2:0], ge};
      data_in.rad  = {in_data.rad[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* src/rmq_div_stage.sv */
`default_nettype none

module rmq_div_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 in_valid,
   input  wire rmq_pkg::div_type     in_data,
   output logic                      out_valid,
   output rmq_pkg::div_type          out_data
);
   import rmq_pkg::*;

   logic       valid_ff;
   div_type    data_ff, data_in;

   // one quotient bit in each of the three lanes, shared divisor
   always_comb begin
      logic [DREM_W:0] t;
      logic [DREM_W:0] den;
      logic            ge;
      data_in = in_data;
      den     = {1'b0, in_data.root};
      for (int s = 0; s < NSLOT; s++) begin
         t  = {in_data.r[s], in_data.nq[s][QUO_W-1]};
         ge = t >= den;
         data_in.r[s]  = ge ? DREM_W'(t - den) : t[DREM_W-1:0];
         data_in.nq[s] = {in_data.nq[s][QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* src/rotation_matrix_to_quaternion_top.sv */
`default_nettype none

// channel   ports                             direction  payload
// req       req_valid req_stall req_m00..m22  in         nine Q2.30 matrix entries
// rsp       rsp_valid rsp_stall rsp_q*        out        Q2.30 quaternion, largest_index
//
// one item per cycle sustained while rsp is not stalled; 67 register stages:
// 3 front stages (candidates, pick, slot select),
// 31 square-root digit stages, 32 divider bit stages (three lanes sharing the root),
// 1 output register
// reset clears the valid bits only; no warm-up after reset
// a stall on a valid rsp freezes the whole pipe; req_stall follows in the same cycle

module rotation_matrix_to_quaternion_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   req_m00,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   req_m01,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   req_m02,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   req_m10,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   req_m11,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   req_m12,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   req_m20,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   req_m21,
   input  wire logic signed [rmq_pkg::DIN_W-1:0]   req_m22,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [rmq_pkg::DIN_W-1:0]        rsp_qw,
   output logic signed [rmq_pkg::DIN_W-1:0]        rsp_qx,
   output logic signed [rmq_pkg::DIN_W-1:0]        rsp_qy,
   output logic signed [rmq_pkg::DIN_W-1:0]        rsp_qz,
   output logic [1:0]                              rsp_largest_index
);
   import rmq_pkg::*;

   // whole pipe moves unless a finished item is held at the output
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   logic       sq_v [SQRT_STEPS+1];
   sqrt_type   sq_d [SQRT_STEPS+1];
   logic       dv_v [DIV_STEPS+1];
   div_type    dv_d [DIV_STEPS+1];

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .m00       (req_m00),
      .m01       (req_m01),
      .m02       (req_m02),
      .m10       (req_m10),
      .m11       (req_m11),
      .m12       (req_m12),
      .m20       (req_m20),
      .m21       (req_m21),
      .m22       (req_m22),
      .out_valid (sq_v[0]),
      .out_data  (sq_d[0])
   );

   // square root, one digit per stage
   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      rmq_sqrt_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sq_v[g]),
         .in_data   (sq_d[g]),
         .out_valid (sq_v[g+1]),
         .out_data  (sq_d[g+1])
      );
   end

   // hand-off: dividend is |num| << 28, its top bits seed the remainder
   always_comb begin
      dv_v[0]      = sq_v[SQRT_STEPS];
      dv_d[0].idx  = sq_d[SQRT_STEPS].side.idx;
      dv_d[0].neg  = sq_d[SQRT_STEPS].side.neg;
      dv_d[0].root = sq_d[SQRT_STEPS].root;
      for (int s = 0; s < NSLOT; s++) begin
         dv_d[0].r[s]  = DREM_W'(sq_d[SQRT_STEPS].side.mag[s][PAIR_W-1:4]);
         dv_d[0].nq[s] = {sq_d[SQRT_STEPS].side.mag[s][3:0], {FRAC_SHIFT{1'b0}}};
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      rmq_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv_v[g]),
         .in_data   (dv_d[g]),
         .out_valid (dv_v[g+1]),
         .out_data  (dv_d[g+1])
      );
   end

   // output register: root into the chosen component, signed quotients elsewhere
   logic                    out_valid_ff;
   logic [DIN_W-1:0]        q_ff [NCOMP];
   logic [DIN_W-1:0]        q_in [NCOMP];
   comp_type                idx_ff;

   always_comb begin
      div_type    d;
      logic [1:0] s;
      d = dv_d[DIV_STEPS];
      for (int j = 0; j < NCOMP; j++) begin
         s = (comp_type'(j) < d.idx) ? 2'(j) : 2'(j - 1);
         if (comp_type'(j) == d.idx) begin
            q_in[j] = DIN_W'(d.root);
         end else begin
            q_in[j] = d.neg[s] ? DIN_W'(-d.nq[s]) : d.nq[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dv_v[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff   <= q_in;
         idx_ff <= dv_d[DIV_STEPS].idx;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_qw            = q_ff[0];
   assign rsp_qx            = q_ff[1];
   assign rsp_qy            = q_ff[2];
   assign rsp_qz            = q_ff[3];
   assign rsp_largest_index = idx_ff;

endmodule

`default_nettype wire

/* bench/rotation_matrix_to_quaternion_top_test.sv */
`default_nettype none

module rotation_matrix_to_quaternion_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rmq_pkg::*;

   // nine matrix entries, row major m00 .. m22
   typedef logic [8:0][DIN_W-1:0] matrix_type;

   typedef struct packed {
      logic [DIN_W-1:0] qw;
      logic [DIN_W-1:0] qx;
      logic [DIN_W-1:0] qy;
      logic [DIN_W-1:0] qz;
      logic [1:0]       largest;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [DIN_W-1:0] req_m00 = '0, req_m01 = '0, req_m02 = '0;
   logic signed [DIN_W-1:0] req_m10 = '0, req_m11 = '0, req_m12 = '0;
   logic signed [DIN_W-1:0] req_m20 = '0, req_m21 = '0, req_m22 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DIN_W-1:0] rsp_qw, rsp_qx, rsp_qy, rsp_qz;
   logic [1:0] rsp_largest_index;

   matrix_type matrix_queue[$];     // items waiting to be driven
   quat_type   quat_expected[$];    // predicted results, oldest first
   int      error_count = 0;
   int      items_sent = 0;
   int      results_seen = 0;
   int      branch_hits[4] = '{0, 0, 0, 0};
   int      req_gap = 0;
   int      rsp_hold = 0;

   rotation_matrix_to_quaternion_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_m00(req_m00), .req_m01(req_m01), .req_m02(req_m02),
      .req_m10(req_m10), .req_m11(req_m11), .req_m12(req_m12),
      .req_m20(req_m20), .req_m21(req_m21), .req_m22(req_m22),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_qw(rsp_qw), .rsp_qx(rsp_qx), .rsp_qy(rsp_qy), .rsp_qz(rsp_qz),
      .rsp_largest_index(rsp_largest_index)
   );

   always #5 clock = ~clock;

   // bitwise integer square root of a 64 bit value
   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // num * 2^28 / root, truncated toward zero
   function automatic logic [DIN_W-1:0] scaled_div(input longint num, input logic [63:0] root);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] q;
      neg = num < 0;
      mag = neg ? 64'(-num) : 64'(num);
      q = (mag << FRAC_SHIFT) / root;
      if (neg) q = -q;
      return q[DIN_W-1:0];
   endfunction

   function automatic quat_type shepperd_quat(input matrix_type m);
      longint a[9];
      longint cand[4];
      longint best;
      logic [63:0] root;
      logic [DIN_W-1:0] r32;
      quat_type res;
      int k;
      for (int i = 0; i < 9; i++) a[i] = longint'($signed(m[8-i]));
      // a[0]=m00 a[1]=m01 a[2]=m02 a[3]=m10 a[4]=m11 a[5]=m12 a[6]=m20 a[7]=m21 a[8]=m22
      cand[0] = (64'sd1 << 30) + a[0] + a[4] + a[8];
      cand[1] = (64'sd1 << 30) + a[0] - a[4] - a[8];
      cand[2] = (64'sd1 << 30) - a[0] + a[4] - a[8];
      cand[3] = (64'sd1 << 30) - a[0] - a[4] + a[8];
      best = cand[0];
      k = 0;
      // strict compare so the earlier candidate wins a tie
      for (int i = 1; i < 4; i++) begin
         if (best < cand[i]) begin
            best = cand[i];
            k = i;
         end
      end
      if (best < 0) best = 0;
      root = int_sqrt(64'(best) << FRAC_SHIFT);
      r32 = root[DIN_W-1:0];
      res.largest = 2'(k);
      case (k)
         0: begin
            res.qw = r32;
            res.qx = scaled_div(a[7] - a[5], root);
            res.qy = scaled_div(a[2] - a[6], root);
            res.qz = scaled_div(a[3] - a[1], root);
         end
         1: begin
            res.qw = scaled_div(a[7] - a[5], root);
            res.qx = r32;
            res.qy = scaled_div(a[1] + a[3], root);
            res.qz = scaled_div(a[2] + a[6], root);
         end
         2: begin
            res.qw = scaled_div(a[2] - a[6], root);
            res.qx = scaled_div(a[1] + a[3], root);
            res.qy = r32;
            res.qz = scaled_div(a[5] + a[7], root);
         end
         default: begin
            res.qw = scaled_div(a[3] - a[1], root);
            res.qx = scaled_div(a[2] + a[6], root);
            res.qy = scaled_div(a[5] + a[7], root);
            res.qz = r32;
         end
      endcase
      return res;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 4) return $urandom_range(20, 80);
      if (p < 25) return $urandom_range(1, 4);
      return 0;
   endfunction

   function automatic logic [DIN_W-1:0] to_q30(input real v);
      real s;
      s = v * 1073741824.0;
      if (s > 2147483647.0) s = 2147483647.0;
      if (s < -2147483648.0) s = -2147483648.0;
      return DIN_W'($rtoi(s));
   endfunction

   task automatic add_entries(input logic [DIN_W-1:0] e00, e01, e02, e10, e11, e12,
                              e20, e21, e22);
      matrix_queue.push_back({e00, e01, e02, e10, e11, e12, e20, e21, e22});
   endtask

   // rotation matrix from a quaternion, normalized here
   task automatic add_rotation(input real w, x, y, z);
      real n;
      n = $sqrt(w*w + x*x + y*y + z*z);
      if (n < 1.0e-9) begin
         w = 1.0;
         n = 1.0;
      end
      w = w / n; x = x / n; y = y / n; z = z / n;
      add_entries(to_q30(1.0 - 2.0*(y*y + z*z)), to_q30(2.0*(x*y - w*z)),
                  to_q30(2.0*(x*z + w*y)),
                  to_q30(2.0*(x*y + w*z)), to_q30(1.0 - 2.0*(x*x + z*z)),
                  to_q30(2.0*(y*z - w*x)),
                  to_q30(2.0*(x*z - w*y)), to_q30(2.0*(y*z + w*x)),
                  to_q30(1.0 - 2.0*(x*x + y*y)));
   endtask

   function automatic real rand_unit();
      return ($itor($urandom_range(0, 2000000)) / 1000000.0) - 1.0;
   endfunction

   // driver: present the next item once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            quat_expected.push_back(shepperd_quat({req_m00, req_m01, req_m02, req_m10,
                                                   req_m11, req_m12, req_m20, req_m21,
                                                   req_m22}));
            items_sent <= items_sent + 1;
         end
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (matrix_queue.size() > 0) begin
            matrix_type mx;
            mx = matrix_queue.pop_front();
            {req_m00, req_m01, req_m02, req_m10, req_m11, req_m12,
             req_m20, req_m21, req_m22} <= mx;
            req_valid <= 1'b1;
            req_gap <= idle_length();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (quat_expected.size() == 0) begin
               $error("result item with no prediction pending");
               error_count <= error_count + 1;
            end else begin
               quat_type ex;
               int bad;
               ex = quat_expected.pop_front();
               bad = 0;
               if (rsp_qw !== ex.qw) begin
                  $error("qw expected %0d got %0d", $signed(ex.qw), rsp_qw);
                  bad++;
               end
               if (rsp_qx !== ex.qx) begin
                  $error("qx expected %0d got %0d", $signed(ex.qx), rsp_qx);
                  bad++;
               end
               if (rsp_qy !== ex.qy) begin
                  $error("qy expected %0d got %0d", $signed(ex.qy), rsp_qy);
                  bad++;
               end
               if (rsp_qz !== ex.qz) begin
                  $error("qz expected %0d got %0d", $signed(ex.qz), rsp_qz);
                  bad++;
               end
               if (rsp_largest_index !== ex.largest) begin
                  $error("largest_index expected %0d got %0d", ex.largest,
                         rsp_largest_index);
                  bad++;
               end
               error_count <= error_count + bad;
               branch_hits[ex.largest] <= branch_hits[ex.largest] + 1;
            end
            results_seen <= results_seen + 1;
         end
         // random back pressure on the result side
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold <= rsp_hold - 1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_hold <= idle_length();
         end
      end
   end

   initial begin
      logic [DIN_W-1:0] mn, mx, one;
      int p;
      mn = 32'h8000_0000;
      mx = 32'h7fff_ffff;
      one = 32'h4000_0000;
      // identity, and half turns about each axis pick w, x, y, z
      add_entries(one, 0, 0, 0, one, 0, 0, 0, one);
      add_rotation(0.0, 1.0, 0.0, 0.0);
      add_rotation(0.0, 0.0, 1.0, 0.0);
      add_rotation(0.0, 0.0, 0.0, 1.0);
      // zero matrix ties all four candidates, w wins
      add_entries(0, 0, 0, 0, 0, 0, 0, 0, 0);
      // ties between x and y, between y and z, between x and z
      add_entries(0, 0, 0, 0, 0, 0, 0, 0, -one);
      add_entries(-one, 0, 0, 0, 0, 0, 0, 0, 0);
      add_entries(0, 0, 0, 0, -one, 0, 0, 0, 0);
      // extreme entries, not rotations
      add_entries(mn, mn, mn, mn, mn, mn, mn, mn, mn);
      add_entries(mx, mx, mx, mx, mx, mx, mx, mx, mx);
      add_entries(mx, mn, mx, mn, mx, mn, mx, mn, mx);
      add_entries(mn, mx, mn, mx, mn, mx, mn, mx, mn);
      add_entries(mx, mx, mn, mn, mn, mx, mx, mn, mn);
      add_entries(mn, mn, mx, mx, mx, mn, mn, mx, mx);
      add_entries(mx, mn, mn, mn, mn, mn, mn, mn, mn);
      add_entries(mn, mx, mx, mx, mx, mx, mx, mx, mn);
      add_entries(32'hffff_ffff, 1, 32'hffff_ffff, 1, 32'hffff_ffff, 1,
                  32'hffff_ffff, 1, 32'hffff_ffff);
      add_rotation(0.5, 0.5, 0.5, 0.5);
      add_rotation(-0.5, 0.5, -0.5, 0.5);

      // random part: rotations, perturbed rotations and raw noise
      for (int i = 0; i < 1400; i++) begin
         p = $urandom_range(0, 99);
         if (p < 60) begin
            add_rotation(rand_unit(), rand_unit(), rand_unit(), rand_unit());
         end else if (p < 80) begin
            matrix_type m;
            add_rotation(rand_unit(), rand_unit(), rand_unit(), rand_unit());
            m = matrix_queue.pop_back();
            for (int j = 0; j < 9; j++)
               m[j] = m[j] + DIN_W'($signed($urandom_range(0, 4095)) - 2048);
            matrix_queue.push_back(m);
         end else begin
            add_entries($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // drain: all driven, all results back, then a latency's worth more
      // checked away from the rising edge so the driver's updates have settled
      while (matrix_queue.size() > 0 || req_valid || quat_expected.size() > 0)
         @(negedge clock);
      repeat (100) @(posedge clock);

      if (quat_expected.size() != 0) begin
         $error("%0d predicted results never arrived", quat_expected.size());
         error_count = error_count + 1;
      end
      $display("%0d matrices sent, %0d quaternions checked", items_sent, results_seen);
      $display("branch counts w %0d x %0d y %0d z %0d", branch_hits[0], branch_hits[1],
               branch_hits[2], branch_hits[3]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
src/rmq_pkg.sv
src/rmq_front.sv
src/rmq_sqrt_stage.sv
src/rmq_div_stage.sv
src/rotation_matrix_to_quaternion_top.sv
bench/rotation_matrix_to_quaternion_top_test.sv
